// ===== src/ptt_pkg.sv =====
// types and codes shared by the periodic timer table
package ptt_pkg;

    localparam int ID_W         = 16;
    localparam int PERIOD_W     = 16;
    localparam int TICK_W       = 32;
    localparam int RESULT_LIMIT = 16;
    localparam int FIRE_W       = $clog2(RESULT_LIMIT + 1);
    localparam int STEP_W       = $clog2(TICK_W);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_PER  = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_FIRE   = 1'b1
    } kind_t;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [ID_W-1:0]     timer_id;
        logic [PERIOD_W-1:0] period;
    } req_beat_t;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] fired_id;
        logic [1:0]      status;
        logic            last;
    } rsp_beat_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
    } entry_t;

endpackage

// ===== src/periodic_timer_table.sv =====
// periodic timer table with a shared serial remainder unit
//
// Holds up to MAX_TIMERS (id, period) timers and a 32-bit tick counter. One request
// beat is taken at a time; req_stall stays high until every result beat of that
// request has been loaded into the output register. An add gives one status beat. A
// remove reads the entries in turn, moves the last entry into the place of each one
// whose id matches, then gives one status beat. A tick finds each stored entry's
// remainder of the tick counter with one shift-subtract unit at one quotient bit per
// cycle, and the table sits in a memory with one read port, read one entry at a time.
// A tick gives one fire beat per due entry, in table order, at most 16, the last one
// flagged; no beat when nothing is due.
module periodic_timer_table
    import ptt_pkg::*;
#(
    parameter int MAX_TIMERS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_beat_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W = $clog2(MAX_TIMERS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_STATUS,
        S_RM_RD,
        S_RM_CHK,
        S_RM_MOVE,
        S_T_RD,
        S_T_LOAD,
        S_T_DIV,
        S_T_HIT,
        S_T_END
    } state_t;

    state_t                state_reg, state_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [1:0]            status_reg, status_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [TICK_W-1:0]     div_reg, div_next;
    logic [PERIOD_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [FIRE_W-1:0]     fire_cnt_reg, fire_cnt_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]       pend_id_reg, pend_id_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_beat_t             rsp_reg, rsp_next;

    entry_t                entry_mem_reg [MAX_TIMERS];
    entry_t                rd_entry_reg;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    entry_t                wr_data;

    logic                  out_free;
    logic [CNT_W-1:0]      cnt_m1;
    logic [PERIOD_W:0]     rem_shift;
    logic [PERIOD_W:0]     rem_diff;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign rem_shift = {rem_reg, div_reg[TICK_W-1]};
    assign rem_diff  = rem_shift - {1'b0, rd_entry_reg.period};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_entry_reg <= entry_mem_reg[rd_addr];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        id_next         = id_reg;
        period_next     = period_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        status_next     = status_reg;
        tick_next       = tick_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        fire_cnt_next   = fire_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = idx_reg[IDX_W-1:0];
        wr_data         = rd_entry_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    id_next       = req.timer_id;
                    period_next   = req.period;
                    idx_next      = '0;
                    status_next   = ST_NOT_FOUND;
                    fire_cnt_next = '0;
                    unique case (req.cmd)
                        CMD_ADD:    state_next = S_ADD;
                        CMD_REMOVE: state_next = S_RM_RD;
                        CMD_TICK:   state_next = S_T_RD;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                if (period_reg == '0)
                begin
                    status_next = ST_ZERO_PER;
                end
                else if (count_reg >= CNT_W'(MAX_TIMERS))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = count_reg[IDX_W-1:0];
                    wr_data     = '{id: id_reg, period: period_reg};
                    count_next  = count_reg + CNT_W'(1);
                    status_next = ST_OK;
                end
                state_next = S_STATUS;
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{kind: KIND_STATUS, fired_id: '0,
                                       status: status_reg, last: 1'b1};
                    state_next     = S_IDLE;
                end
            end
            S_RM_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = S_RM_CHK;
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_RM_CHK:
            begin
                if (rd_entry_reg.id == id_reg)
                begin
                    status_next = ST_OK;
                    count_next  = cnt_m1;
                    rd_en       = 1'b1;
                    rd_addr     = cnt_m1[IDX_W-1:0];
                    state_next  = S_RM_MOVE;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_RM_RD;
                end
            end
            S_RM_MOVE:
            begin
                // last entry fills the hole, then is checked again
                wr_en      = 1'b1;
                state_next = S_RM_RD;
            end
            S_T_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = S_T_LOAD;
                end
                else
                begin
                    state_next = S_T_END;
                end
            end
            S_T_LOAD:
            begin
                if (rd_entry_reg.period == '0)
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_T_RD;
                end
                else
                begin
                    div_next   = tick_reg;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = S_T_DIV;
                end
            end
            S_T_DIV:
            begin
                div_next = {div_reg[TICK_W-2:0], 1'b0};
                if (!rem_diff[PERIOD_W])
                begin
                    rem_next = rem_diff[PERIOD_W-1:0];
                end
                else
                begin
                    rem_next = rem_shift[PERIOD_W-1:0];
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(TICK_W - 1))
                begin
                    state_next = S_T_HIT;
                end
            end
            S_T_HIT:
            begin
                if (rem_reg == '0 && fire_cnt_reg < FIRE_W'(RESULT_LIMIT))
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = '{kind: KIND_FIRE, fired_id: pend_id_reg,
                                               status: ST_OK, last: 1'b0};
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = rd_entry_reg.id;
                        fire_cnt_next   = fire_cnt_reg + FIRE_W'(1);
                        idx_next        = idx_reg + CNT_W'(1);
                        state_next      = S_T_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_T_RD;
                end
            end
            S_T_END:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{kind: KIND_FIRE, fired_id: pend_id_reg,
                                           status: ST_OK, last: 1'b1};
                    end
                    pend_valid_next = 1'b0;
                    tick_next       = tick_reg + TICK_W'(1);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            tick_reg       <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            step_reg       <= '0;
            fire_cnt_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            tick_reg       <= tick_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            idx_reg        <= idx_next;
            step_reg       <= step_next;
            fire_cnt_reg   <= fire_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        period_reg  <= period_next;
        status_reg  <= status_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        pend_id_reg <= pend_id_next;
        rsp_reg     <= rsp_next;
    end

endmodule
